// ----- hw/rtl/dirty_rect_merge_queue_unit_assert.svh -----
// Assertion macros shared by the dirty rectangle merge queue RTL.
`ifndef DIRTY_RECT_MERGE_QUEUE_UNIT_ASSERT_SVH
`define DIRTY_RECT_MERGE_QUEUE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DRMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DRMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DRMQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DRMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/drmq_pkg.sv -----
// Types and constants of the dirty rectangle merge queue.
package drmq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int IN_DATA_W       = 104;
  localparam int OUT_DATA_W      = 120;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DRAIN = 2'd1,
    OP_ASK   = 2'd2,
    OP_COUNT = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_PIECE  = 2'd0,
    KIND_ADDED  = 2'd1,
    KIND_DRAINED = 2'd2,
    KIND_ANSWER = 2'd3
  } kind_t;

  typedef struct packed {
    logic        [15:0] window;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- hw/rtl/drmq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module drmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/dirty_rect_merge_queue_unit.sv -----
// Dirty rectangle merge queue: a ring of redraw rectangles with merge, drain and queries.
//
// The input stream carries one command per transfer: tuser is the opcode (add,
// drain, ask, count) and tdata holds window, rectangle corners and pixel budget.
// The output stream returns results; tuser is the result kind and tlast marks
// the final result of a command. Add and the queries return one result; a drain
// returns one draw piece per row group taken plus a closing status result.
// The block works on one command at a time and holds in_tready low until the
// last result of the command has been transferred.
// Add and ask read the queue entries one at a time through the entry RAM, each
// entry through a read state and a check state. Each draw piece passes the
// 24-step restoring divider that cuts the budget by the entry width and then a
// multiply state before it is posted.
// A stalled receiver holds the result register; no work proceeds meanwhile.
// Reset empties the queue at once; entry storage needs no clearing.
module dirty_rect_merge_queue_unit
  import drmq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // window_id, left, top, right, bottom, pixel_budget
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // piece_window, piece_x, piece_y, piece_width, piece_rows, pixels_done,
  // win_queued, queued_count, dropped, merged, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

`include "dirty_rect_merge_queue_unit_assert.svh"

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_RD     = 11'b00000000010,
    S_CHK    = 11'b00000000100,
    S_APPEND = 11'b00000001000,
    S_DRN    = 11'b00000010000,
    S_DRN_RD = 11'b00000100000,
    S_DRN_LD = 11'b00001000000,
    S_DIV    = 11'b00010000000,
    S_MUL    = 11'b00100000000,
    S_UPD    = 11'b01000000000,
    S_WAIT   = 11'b10000000000
  } state_t;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    next_slot = (i == LAST_SLOT) ? '0 : i + 1'b1;
  endfunction

  state_t state_r, state_nxt;
  logic [AW-1:0] oldest_r, oldest_nxt, append_r, append_nxt, addr_r, addr_nxt;
  logic [CW-1:0] count_r, count_nxt, left_r, left_nxt;
  opcode_t op_r, op_nxt;
  entry_t cmd_r, cmd_nxt, ent_r, ent_nxt;
  logic [23:0] budget_r, budget_nxt, done_r, done_nxt, dvd_r, dvd_nxt, pix_r, pix_nxt;
  logic [16:0] w_r, w_nxt, h_r, h_nxt, cut_r, cut_nxt, rem_r, rem_nxt;
  logic [4:0] step_r, step_nxt;

  logic out_valid_r, out_valid_nxt, o_last_r, o_last_nxt;
  kind_t o_kind_r, o_kind_nxt;
  logic [15:0] o_win_r, o_win_nxt, o_x_r, o_x_nxt, o_y_r, o_y_nxt;
  logic [16:0] o_w_r, o_w_nxt, o_rows_r, o_rows_nxt;
  logic [23:0] o_done_r, o_done_nxt;
  logic o_q_r, o_q_nxt, o_drop_r, o_drop_nxt, o_merge_r, o_merge_nxt;
  logic [5:0] o_cnt_r, o_cnt_nxt;

  logic we;
  logic [AW-1:0] waddr;
  entry_t wdata, rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  entry_t in_ent;
  logic signed [17:0] w_calc, h_calc;
  logic [17:0] trial;
  logic [23:0] q_fin;
  logic [33:0] prod;

  assign in_ent.window = in_tdata[15:0];
  assign in_ent.left   = in_tdata[31:16];
  assign in_ent.top    = in_tdata[47:32];
  assign in_ent.right  = in_tdata[63:48];
  assign in_ent.bottom = in_tdata[79:64];

  drmq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr_r),
    .rdata (rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  always_comb begin
    state_nxt = state_r;
    oldest_nxt = oldest_r; append_nxt = append_r; addr_nxt = addr_r;
    count_nxt = count_r; left_nxt = left_r; op_nxt = op_r;
    cmd_nxt = cmd_r; ent_nxt = ent_r; budget_nxt = budget_r; done_nxt = done_r;
    dvd_nxt = dvd_r; pix_nxt = pix_r; w_nxt = w_r; h_nxt = h_r; cut_nxt = cut_r;
    rem_nxt = rem_r; step_nxt = step_r;
    out_valid_nxt = out_valid_r; o_last_nxt = o_last_r; o_kind_nxt = o_kind_r;
    o_win_nxt = o_win_r; o_x_nxt = o_x_r; o_y_nxt = o_y_r; o_w_nxt = o_w_r;
    o_rows_nxt = o_rows_r; o_done_nxt = o_done_r; o_q_nxt = o_q_r;
    o_cnt_nxt = o_cnt_r; o_drop_nxt = o_drop_r; o_merge_nxt = o_merge_r;
    we = 1'b0; waddr = addr_r; wdata = cmd_r;
    w_calc = 18'(signed'({rdata.right[15], rdata.right})) -
             18'(signed'({rdata.left[15], rdata.left})) + 18'sd1;
    h_calc = 18'(signed'({rdata.bottom[15], rdata.bottom})) -
             18'(signed'({rdata.top[15], rdata.top})) + 18'sd1;
    trial = {rem_r, dvd_r[23]};
    q_fin = dvd_r;
    prod = w_r * cut_r;

    // Every posted result has all fields set; unused ones are zero.
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = opcode_t'(in_tuser);
          cmd_nxt = in_ent;
          budget_nxt = in_tdata[103:80];
          done_nxt = '0;
          o_win_nxt = '0; o_x_nxt = '0; o_y_nxt = '0; o_w_nxt = '0; o_rows_nxt = '0;
          o_done_nxt = '0; o_q_nxt = 1'b0; o_drop_nxt = 1'b0; o_merge_nxt = 1'b0;
          o_cnt_nxt = 6'(count_r);
          o_last_nxt = 1'b1;
          case (opcode_t'(in_tuser))
            OP_ADD: begin
              if (in_ent.left > in_ent.right || in_ent.top > in_ent.bottom) begin
                o_kind_nxt = KIND_ADDED; out_valid_nxt = 1'b1; state_nxt = S_WAIT;
              end else if (count_r > CW'(1)) begin
                addr_nxt = next_slot(oldest_r); left_nxt = count_r - 1'b1;
                state_nxt = S_RD;
              end else begin
                state_nxt = S_APPEND;
              end
            end
            OP_DRAIN: state_nxt = S_DRN;
            OP_ASK: begin
              if (count_r != '0) begin
                addr_nxt = oldest_r; left_nxt = count_r; state_nxt = S_RD;
              end else begin
                o_kind_nxt = KIND_ANSWER; out_valid_nxt = 1'b1; state_nxt = S_WAIT;
              end
            end
            default: begin
              o_kind_nxt = KIND_ANSWER; out_valid_nxt = 1'b1; state_nxt = S_WAIT;
            end
          endcase
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        if (rdata.window == cmd_r.window) begin
          if (op_r == OP_ADD) begin
            we = 1'b1;
            wdata.window = rdata.window;
            wdata.left   = (cmd_r.left < rdata.left) ? cmd_r.left : rdata.left;
            wdata.top    = (cmd_r.top < rdata.top) ? cmd_r.top : rdata.top;
            wdata.right  = (cmd_r.right > rdata.right) ? cmd_r.right : rdata.right;
            wdata.bottom = (cmd_r.bottom > rdata.bottom) ? cmd_r.bottom : rdata.bottom;
            o_kind_nxt = KIND_ADDED; o_merge_nxt = 1'b1;
          end else begin
            o_kind_nxt = KIND_ANSWER; o_q_nxt = 1'b1;
          end
          out_valid_nxt = 1'b1; state_nxt = S_WAIT;
        end else if (left_r == CW'(1)) begin
          if (op_r == OP_ADD) begin
            state_nxt = S_APPEND;
          end else begin
            o_kind_nxt = KIND_ANSWER; out_valid_nxt = 1'b1; state_nxt = S_WAIT;
          end
        end else begin
          left_nxt = left_r - 1'b1; addr_nxt = next_slot(addr_r); state_nxt = S_RD;
        end
      end
      S_APPEND: begin
        o_kind_nxt = KIND_ADDED;
        if (count_r >= FULL_CNT) begin
          o_drop_nxt = 1'b1;
        end else begin
          we = 1'b1; waddr = append_r; wdata = cmd_r;
          append_nxt = next_slot(append_r);
          count_nxt = count_r + 1'b1;
          o_cnt_nxt = 6'(count_r + 1'b1);
        end
        out_valid_nxt = 1'b1; state_nxt = S_WAIT;
      end
      S_DRN: begin
        if (count_r == '0 || budget_r == '0) begin
          o_kind_nxt = KIND_DRAINED; o_done_nxt = done_r; o_cnt_nxt = 6'(count_r);
          o_win_nxt = '0; o_x_nxt = '0; o_y_nxt = '0; o_w_nxt = '0; o_rows_nxt = '0;
          o_last_nxt = 1'b1; out_valid_nxt = 1'b1; state_nxt = S_WAIT;
        end else begin
          addr_nxt = oldest_r; state_nxt = S_DRN_RD;
        end
      end
      S_DRN_RD: state_nxt = S_DRN_LD;
      S_DRN_LD: begin
        ent_nxt = rdata;
        w_nxt = w_calc[16:0];
        h_nxt = h_calc[16:0];
        rem_nxt = '0; dvd_nxt = budget_r; step_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (trial >= {1'b0, w_r}) begin
          rem_nxt = 17'(trial - {1'b0, w_r}); dvd_nxt = {dvd_r[22:0], 1'b1};
        end else begin
          rem_nxt = trial[16:0]; dvd_nxt = {dvd_r[22:0], 1'b0};
        end
        q_fin = dvd_nxt;
        step_nxt = step_r + 1'b1;
        if (step_r == 5'd23) begin
          if (q_fin == '0) begin
            o_kind_nxt = KIND_DRAINED; o_done_nxt = done_r; o_cnt_nxt = 6'(count_r);
            o_win_nxt = '0; o_x_nxt = '0; o_y_nxt = '0; o_w_nxt = '0; o_rows_nxt = '0;
            o_last_nxt = 1'b1; out_valid_nxt = 1'b1; state_nxt = S_WAIT;
          end else begin
            cut_nxt = (q_fin > {7'd0, h_r}) ? h_r : q_fin[16:0];
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        pix_nxt = prod[23:0];
        o_kind_nxt = KIND_PIECE; o_win_nxt = ent_r.window;
        o_x_nxt = ent_r.left; o_y_nxt = ent_r.top; o_w_nxt = w_r; o_rows_nxt = cut_r;
        o_done_nxt = '0; o_cnt_nxt = '0; o_q_nxt = 1'b0; o_drop_nxt = 1'b0;
        o_merge_nxt = 1'b0; o_last_nxt = 1'b0;
        out_valid_nxt = 1'b1; state_nxt = S_WAIT;
      end
      S_UPD: begin
        budget_nxt = budget_r - pix_r;
        done_nxt = done_r + pix_r;
        if (cut_r == h_r) begin
          oldest_nxt = next_slot(oldest_r); count_nxt = count_r - 1'b1;
        end else begin
          we = 1'b1; waddr = oldest_r; wdata = ent_r;
          wdata.top = ent_r.top + signed'(cut_r[15:0]);
        end
        state_nxt = S_DRN;
      end
      S_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt = o_last_r ? S_IDLE : S_UPD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oldest_r <= '0;
      append_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oldest_r <= oldest_nxt;
      append_r <= append_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt; left_r <= left_nxt; op_r <= op_nxt; cmd_r <= cmd_nxt;
    ent_r <= ent_nxt; budget_r <= budget_nxt; done_r <= done_nxt; dvd_r <= dvd_nxt;
    pix_r <= pix_nxt; w_r <= w_nxt; h_r <= h_nxt; cut_r <= cut_nxt; rem_r <= rem_nxt;
    step_r <= step_nxt; o_last_r <= o_last_nxt; o_kind_r <= o_kind_nxt;
    o_win_r <= o_win_nxt; o_x_r <= o_x_nxt; o_y_r <= o_y_nxt; o_w_r <= o_w_nxt;
    o_rows_r <= o_rows_nxt; o_done_r <= o_done_nxt; o_q_r <= o_q_nxt;
    o_cnt_r <= o_cnt_nxt; o_drop_r <= o_drop_nxt; o_merge_r <= o_merge_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {5'd0, o_merge_r, o_drop_r, o_cnt_r, o_q_r, o_done_r,
                       o_rows_r, o_w_r, o_y_r, o_x_r, o_win_r};

  `DRMQ_ASSERT(a_count_bound, clk, rst_n, count_r <= FULL_CNT, "queue count above depth")
  `DRMQ_ASSERT(a_idle_no_result, clk, rst_n, !(in_tready && out_valid_r),
               "ready for input while a result is pending")
  `DRMQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready,
                    "block ready again right after accepting a command")
  `DRMQ_ASSERT_NEXT(a_piece_not_last, clk, rst_n, state_r == S_MUL,
                    out_valid_r && !o_last_r, "draw piece not posted as non-final result")

endmodule
